@@ src/swmpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmpd_pkg
// Shared types, constants, the clipped absolute difference used by the
// window cells and the two-input minimum used by the tree and the top level.
// ----------------------------------------------------------------------------
package swmpd_pkg;

   localparam int SAMPLE_W = 32;
   localparam int DIFF_W   = 31;
   localparam int WSIZE_W  = 7;

   // start value of the running minimum, also "no pair below 2^30"
   localparam logic [DIFF_W-1:0] MIN_START = 31'h4000_0000;

   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd2;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic                       load;
      logic signed [SAMPLE_W-1:0] sample;
   } cell_ctl_type;

   // |a - b| without wrap, clipped to MIN_START
   function automatic logic [DIFF_W-1:0] abs_clip(input logic signed [SAMPLE_W-1:0] a,
                                                  input logic signed [SAMPLE_W-1:0] b);
      logic signed [SAMPLE_W:0] d;
      logic        [SAMPLE_W:0] m;
      d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      m = d[SAMPLE_W] ? (SAMPLE_W+1)'(-d) : (SAMPLE_W+1)'(d);
      if (m >= (SAMPLE_W+1)'(MIN_START)) begin
         return MIN_START;
      end
      return m[DIFF_W-1:0];
   endfunction

   function automatic logic [DIFF_W-1:0] min2(input logic [DIFF_W-1:0] a,
                                              input logic [DIFF_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

@@ src/swmpd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmpd_cell
// One window slot: holds a sample, shifts it on to the next slot when a
// request is loaded and registers its clipped distance to the new sample.
// ----------------------------------------------------------------------------
module swmpd_cell #(
   parameter int CNT_W = 6,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  swmpd_pkg::cell_ctl_type              ctl,
   input  logic [CNT_W-1:0]                     cmp_cnt,
   input  logic signed [swmpd_pkg::SAMPLE_W-1:0] prev_value,
   output logic signed [swmpd_pkg::SAMPLE_W-1:0] held_value,
   output logic [swmpd_pkg::DIFF_W-1:0]          diff_value
);
   import swmpd_pkg::*;

   logic signed [SAMPLE_W-1:0] held_ff;
   logic        [DIFF_W-1:0]   diff_ff;
   logic                       active;

   // only the most recent cmp_cnt slots take part
   assign active = CNT_W'(INDEX) < cmp_cnt;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         held_ff <= prev_value;
         diff_ff <= active ? abs_clip(ctl.sample, held_ff) : MIN_START;
      end
   end

   assign held_value = held_ff;
   assign diff_value = diff_ff;

endmodule

@@ src/swmpd_min_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmpd_min_tree
// Registered binary minimum tree, one level per cycle, free running.
// Missing leaves are padded with the start value.
// ----------------------------------------------------------------------------
module swmpd_min_tree #(
   parameter int LEAVES = 63
) (
   input  logic                          clock,
   input  logic [swmpd_pkg::DIFF_W-1:0]  leaf_in [LEAVES],
   output logic [swmpd_pkg::DIFF_W-1:0]  root
);
   import swmpd_pkg::*;

   localparam int LEVELS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
   localparam int PAD    = 1 << LEVELS;
   localparam int INNER  = PAD - 1;

   logic [DIFF_W-1:0] leaf    [PAD];
   logic [DIFF_W-1:0] node_ff [INNER];

   for (genvar j = 0; j < PAD; j++) begin : g_leaf
      if (j < LEAVES) begin : g_real
         assign leaf[j] = leaf_in[j];
      end else begin : g_pad
         assign leaf[j] = MIN_START;
      end
   end

   // heap order: node i has children 2i+1 and 2i+2
   for (genvar i = 0; i < INNER; i++) begin : g_node
      logic [DIFF_W-1:0] lhs;
      logic [DIFF_W-1:0] rhs;
      if (2*i+1 < INNER) begin : g_inner
         assign lhs = node_ff[2*i+1];
         assign rhs = node_ff[2*i+2];
      end else begin : g_bottom
         assign lhs = leaf[2*i+1-INNER];
         assign rhs = leaf[2*i+2-INNER];
      end
      always_ff @(posedge clock) begin
         node_ff[i] <= min2(lhs, rhs);
      end
   end

   assign root = node_ff[0];

endmodule

@@ src/sliding_window_min_pair_difference.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_min_pair_difference
// Running minimum of the absolute difference between a new sample and the
// samples held in a sliding window, built as a shift chain of cells feeding
// a registered minimum tree.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  payload
//   req_      in         req_valid / req_ready      sample, first_sample, last_sample
//   rsp_      out        rsp_valid / rsp_ready      min_difference, final_res
//   csr_      in         csr_write_enable           write_data (window size)
//
// Each request passes through the cell compare, L = ceil(log2(WINDOW_DEPTH-1))
// registered tree levels (L = 6 at depth 64) and the update, one request at a
// time; its response then waits in the holding slot for the output register.
// The next request may be taken in the cycle its predecessor's response
// leaves the holding slot. Reset clears control state and the running minimum;
// window contents stay until overwritten. A stalled response is held in the
// output register while the next request is already being worked on.
// ----------------------------------------------------------------------------
module sliding_window_min_pair_difference #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [swmpd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_first_sample,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [swmpd_pkg::DIFF_W-1:0]         rsp_min_difference,
   output logic                                 rsp_final_res,
   input  logic                                 csr_write_enable,
   input  logic [swmpd_pkg::WSIZE_W-1:0]        csr_write_data
);
   import swmpd_pkg::*;

   localparam int HELD   = WINDOW_DEPTH - 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH);
   localparam int LEVELS = (HELD > 1) ? $clog2(HELD) : 1;
   localparam int TW     = $clog2(LEVELS + 1);

   localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(HELD);

   logic [WSIZE_W-1:0] window_size_ff;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [DIFF_W-1:0]  running_min_ff, running_min_in;
   logic               busy_ff, busy_in;
   logic [TW-1:0]      tick_ff, tick_in;
   logic               last_ff, last_in;
   logic               pending_ff, pending_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIFF_W-1:0]  rsp_min_ff, rsp_min_in;
   logic               rsp_final_ff, rsp_final_in;

   logic               accept;
   logic               drain;
   logic               finish;
   logic [CNT_W-1:0]   fill_base;
   logic [CNT_W-1:0]   limit;
   logic [CNT_W-1:0]   cmp_cnt;
   cell_ctl_type       ctl;

   logic signed [SAMPLE_W-1:0] held [HELD];
   logic        [DIFF_W-1:0]   diff [HELD];
   logic        [DIFF_W-1:0]   tree_min;

   // holding slot empties into the output register when that is free
   assign drain     = pending_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff && (!pending_ff || drain);
   assign accept    = req_valid && req_ready;
   assign finish    = busy_ff && (tick_ff == '0);

   always_comb begin
      fill_base = req_first_sample ? '0 : fill_ff;
      if (window_size_ff == '0) begin
         limit = '0;
      end else if (32'(window_size_ff) > WINDOW_DEPTH) begin
         limit = FILL_MAX;
      end else begin
         limit = CNT_W'(window_size_ff - WSIZE_W'(1));
      end
      cmp_cnt = (limit < fill_base) ? limit : fill_base;
   end

   assign ctl.load   = accept;
   assign ctl.sample = req_sample;

   for (genvar k = 0; k < HELD; k++) begin : g_cell
      logic signed [SAMPLE_W-1:0] prev;
      if (k == 0) begin : g_head
         assign prev = req_sample;
      end else begin : g_link
         assign prev = held[k-1];
      end
      swmpd_cell #(
         .CNT_W (CNT_W),
         .INDEX (k)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cmp_cnt    (cmp_cnt),
         .prev_value (prev),
         .held_value (held[k]),
         .diff_value (diff[k])
      );
   end

   swmpd_min_tree #(
      .LEAVES (HELD)
   ) u_tree (
      .clock   (clock),
      .leaf_in (diff),
      .root    (tree_min)
   );

   always_comb begin
      fill_in        = fill_ff;
      running_min_in = running_min_ff;
      busy_in        = busy_ff;
      tick_in        = tick_ff;
      last_in        = last_ff;
      pending_in     = pending_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_min_in     = rsp_min_ff;
      rsp_final_in   = rsp_final_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (drain) begin
         pending_in   = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_min_in   = running_min_ff;
         rsp_final_in = last_ff;
      end

      if (accept) begin
         busy_in = 1'b1;
         tick_in = TW'(LEVELS);
         last_in = req_last_sample;
         fill_in = (fill_base == FILL_MAX) ? fill_base : fill_base + CNT_W'(1);
         if (req_first_sample) begin
            running_min_in = MIN_START;
         end
      end else if (finish) begin
         busy_in        = 1'b0;
         pending_in     = 1'b1;
         running_min_in = min2(running_min_ff, tree_min);
      end else if (busy_ff) begin
         tick_in = tick_ff - TW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WSIZE_RESET;
         fill_ff        <= '0;
         running_min_ff <= MIN_START;
         busy_ff        <= 1'b0;
         tick_ff        <= '0;
         pending_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_size_ff <= csr_write_data;
         end
         fill_ff        <= fill_in;
         running_min_ff <= running_min_in;
         busy_ff        <= busy_in;
         tick_ff        <= tick_in;
         pending_ff     <= pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_min_difference = rsp_min_ff;
   assign rsp_final_res      = rsp_final_ff;

endmodule

@@ src/swmpd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmpd_checker
// Port-level checks on the sliding window minimum block, bound to the top.
// ----------------------------------------------------------------------------
module swmpd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [swmpd_pkg::DIFF_W-1:0]         rsp_min_difference,
   input logic                                 rsp_final_res
);
   import swmpd_pkg::*;

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_difference)
                                  && $stable(rsp_final_res))
      else $error("response changed while stalled");

   // the minimum never exceeds its start value
   a_min_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_difference <= MIN_START)
      else $error("minimum above start value");

   // one request in the tree at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sliding_window_min_pair_difference swmpd_checker u_swmpd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_min_difference (rsp_min_difference),
   .rsp_final_res      (rsp_final_res)
);
